FILE: src/abb_pkg.sv
package abb_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TEXTURE_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEXTURE_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_POS_X          = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_POS_Y          = 3'd4;

  localparam int unsigned CfgDataW = 12;
  localparam int unsigned DimW     = 12;
  localparam int unsigned PosW     = 11;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned IndexW   = 22;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  localparam int unsigned MAX_DIM_DEF = 2048;

  localparam logic [DimW-1:0] SCREEN_WIDTH_RST   = 12'd1280;
  localparam logic [DimW-1:0] TEXTURE_WIDTH_RST  = 12'd64;
  localparam logic [DimW-1:0] TEXTURE_HEIGHT_RST = 12'd64;
  localparam logic [PosW-1:0] POS_X_RST          = 11'd200;
  localparam logic [PosW-1:0] POS_Y_RST          = 11'd200;

  typedef struct packed {
    logic [ChanW-1:0] tex_blue;
    logic [ChanW-1:0] tex_green;
    logic [ChanW-1:0] tex_red;
    logic [ChanW-1:0] tex_alpha;
    logic [ChanW-1:0] dst_blue;
    logic [ChanW-1:0] dst_green;
    logic [ChanW-1:0] dst_red;
  } pixel_t;

  // dst + floor(alpha * (src - dst) / 256)
  function automatic logic [ChanW-1:0] blend(input logic [ChanW-1:0] src,
                                             input logic [ChanW-1:0] dst,
                                             input logic [ChanW-1:0] alpha);
    logic signed [ChanW:0]       diff;
    logic signed [2*ChanW+1:0]   prod;
    logic signed [2*ChanW+1:0]   q;
    diff = $signed({1'b0, src}) - $signed({1'b0, dst});
    prod = $signed({1'b0, alpha}) * diff;
    q    = prod >>> ChanW;
    return dst + q[ChanW-1:0];
  endfunction

endpackage

FILE: src/alpha_blend_blitter_top.sv
// Alpha-blending sprite blitter.
// Input stream (s_axis): one texture pixel per transaction in row-major order, together
// with the destination pixel already read from the framebuffer. Output stream (m_axis):
// destination pixel index and the three blended channels in tdata, the clip flag in
// tuser and the final pixel of the rectangle in tlast.
// Configuration (cfg_*): register index plus data; any write to a known register also
// restarts the walk at the top-left pixel. Write only while the block is drained.
// Pipeline: an accepted pixel passes the input stage register, then the result
// register holding the blend. Throughput: one pixel per clock while the output is
// not stalled; the index path is one 11x12 multiply plus a three-input 22-bit add,
// the blend one 9x9 multiply per channel. Stall: when the receiver drops tready the
// result holds and one more pixel is taken into an empty input stage; after that
// s_axis_tready falls until the output moves.
// Reset: pipeline empties, counters clear and the registers return to their
// defaults (screen 1280 wide, 64x64 texture at column 200, row 200).
module alpha_blend_blitter_top #(
  parameter int unsigned MAX_DIM = abb_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [abb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [abb_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tex_blue, tex_green, tex_red, tex_alpha, dst_blue, dst_green, dst_red
  input  logic [abb_pkg::InDataW-1:0]   s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_index[21:0], out_blue, out_green, out_red, 2 zero bits
  output logic [abb_pkg::OutDataW-1:0]  m_axis_tdata,
  // outside
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int unsigned CW   = $clog2(MAX_DIM);
  localparam int unsigned DW   = (CW + 1 > abb_pkg::DimW) ? CW + 1 : abb_pkg::DimW;
  localparam int unsigned DCW  = ((CW > abb_pkg::PosW) ? CW : abb_pkg::PosW) + 1;
  localparam int unsigned IW   = abb_pkg::IndexW;
  localparam int unsigned PW   = abb_pkg::PosW + abb_pkg::DimW;
  localparam int unsigned CH   = abb_pkg::ChanW;

  // config registers
  logic [abb_pkg::DimW-1:0] screen_w_q, tex_w_q, tex_h_q;
  logic [abb_pkg::PosW-1:0] pos_x_q, pos_y_q;
  logic                     cfg_hit;

  // traversal state
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [IW-1:0] row_base_q, row_base_d;

  // stage 1 (input register) and stage 2 (result register)
  logic            v1_q, v2_q;
  abb_pkg::pixel_t pix1_q;
  logic [IW-1:0]   idx1_q, idx2_q;
  logic            outside1_q, outside2_q, last1_q, last2_q;
  logic [CH-1:0]   blue2_q, green2_q, red2_q;

  logic            s_acc, adv1, adv2;
  abb_pkg::pixel_t pix_in;
  logic [DW-1:0]   tw, th;
  logic [DCW-1:0]  dst_col;
  logic [PW-1:0]   base_prod;
  logic [IW-1:0]   idx_in;
  logic            row_end, col_end, last_in, outside_in;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_index_i)
      abb_pkg::REG_SCREEN_WIDTH, abb_pkg::REG_TEXTURE_WIDTH,
      abb_pkg::REG_TEXTURE_HEIGHT, abb_pkg::REG_POS_X, abb_pkg::REG_POS_Y: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
    cfg_hit = cfg_hit & cfg_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= abb_pkg::SCREEN_WIDTH_RST;
      tex_w_q    <= abb_pkg::TEXTURE_WIDTH_RST;
      tex_h_q    <= abb_pkg::TEXTURE_HEIGHT_RST;
      pos_x_q    <= abb_pkg::POS_X_RST;
      pos_y_q    <= abb_pkg::POS_Y_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        abb_pkg::REG_SCREEN_WIDTH:   screen_w_q <= cfg_data_i;
        abb_pkg::REG_TEXTURE_WIDTH:  tex_w_q    <= cfg_data_i;
        abb_pkg::REG_TEXTURE_HEIGHT: tex_h_q    <= cfg_data_i;
        abb_pkg::REG_POS_X:          pos_x_q    <= cfg_data_i[abb_pkg::PosW-1:0];
        abb_pkg::REG_POS_Y:          pos_y_q    <= cfg_data_i[abb_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 2 empties on output transaction, stage 1 moves when stage 2 frees
  assign adv2          = !v2_q || m_axis_tready;
  assign adv1          = v1_q && adv2;
  assign s_axis_tready = !v1_q || adv2;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // clamped texture size: zero counts as one, saturate at MAX_DIM
  always_comb begin
    if (tex_w_q == '0) begin
      tw = DW'(1);
    end else if (DW'(tex_w_q) > DW'(MAX_DIM)) begin
      tw = DW'(MAX_DIM);
    end else begin
      tw = DW'(tex_w_q);
    end
    if (tex_h_q == '0) begin
      th = DW'(1);
    end else if (DW'(tex_h_q) > DW'(MAX_DIM)) begin
      th = DW'(MAX_DIM);
    end else begin
      th = DW'(tex_h_q);
    end
  end

  // tex_blue is the lowest byte on the bus but the top member of the struct
  assign pix_in     = abb_pkg::pixel_t'({s_axis_tdata[7:0], s_axis_tdata[15:8],
                                         s_axis_tdata[23:16], s_axis_tdata[31:24],
                                         s_axis_tdata[39:32], s_axis_tdata[47:40],
                                         s_axis_tdata[55:48]});
  assign dst_col    = DCW'(pos_x_q) + DCW'(col_q);
  assign base_prod  = PW'(pos_y_q) * PW'(screen_w_q);
  assign idx_in     = base_prod[IW-1:0] + row_base_q + IW'(dst_col);
  assign outside_in = DCW'(screen_w_q) <= dst_col;
  assign row_end    = (DW'(col_q) + DW'(1)) >= tw;
  assign col_end    = (DW'(row_q) + DW'(1)) >= th;
  assign last_in    = row_end && col_end;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    if (cfg_hit || (s_acc && last_in)) begin
      col_d      = '0;
      row_d      = '0;
      row_base_d = '0;
    end else if (s_acc && row_end) begin
      col_d      = '0;
      row_d      = row_q + CW'(1);
      row_base_d = row_base_q + IW'(screen_w_q);
    end else if (s_acc) begin
      col_d      = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pix1_q     <= pix_in;
      idx1_q     <= idx_in;
      outside1_q <= outside_in;
      last1_q    <= last_in;
    end
    if (adv1) begin
      idx2_q     <= idx1_q;
      outside2_q <= outside1_q;
      last2_q    <= last1_q;
      blue2_q    <= abb_pkg::blend(pix1_q.tex_blue, pix1_q.dst_blue, pix1_q.tex_alpha);
      green2_q   <= abb_pkg::blend(pix1_q.tex_green, pix1_q.dst_green, pix1_q.tex_alpha);
      red2_q     <= abb_pkg::blend(pix1_q.tex_red, pix1_q.dst_red, pix1_q.tex_alpha);
    end
  end

  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {2'b00, red2_q, green2_q, blue2_q, idx2_q};
  assign m_axis_tuser  = outside2_q;
  assign m_axis_tlast  = last2_q;

  // counters never leave the clamped rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DW'(col_q) < tw) && (DW'(row_q) < th))
    else $error("traversal counter outside texture rectangle");

  // the final pixel restarts the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && last_in) |=> (col_q == '0) && (row_q == '0) && (row_base_q == '0))
    else $error("counters not cleared after final pixel");

  // a stalled result is not overwritten by the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !m_axis_tready) |=> v2_q && $stable(idx2_q) && $stable(blue2_q)
                                 && $stable(last2_q))
    else $error("stalled result changed");

  // stage 1 holds while stage 2 is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv2) |=> v1_q && $stable(idx1_q))
    else $error("input stage lost a pixel under stall");

endmodule

FILE: test/alpha_blend_blitter_top_tb.sv
`timescale 1ns / 1ps

module alpha_blend_blitter_top_tb;

  localparam int unsigned CfgIdxW  = abb_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = abb_pkg::CfgDataW;
  localparam int unsigned DimW     = abb_pkg::DimW;
  localparam int unsigned PosW     = abb_pkg::PosW;
  localparam int unsigned ChanW    = abb_pkg::ChanW;
  localparam int unsigned IndexW   = abb_pkg::IndexW;
  localparam int unsigned InDataW  = abb_pkg::InDataW;
  localparam int unsigned OutDataW = abb_pkg::OutDataW;
  localparam int unsigned MaxDim   = abb_pkg::MAX_DIM_DEF;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned LIMIT = 400_000;
  localparam int unsigned RAND_ITEMS = 1600;
  localparam int unsigned BIG_ROW_ITEMS = 260;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned LIGHT_PCT = 22;
  localparam int unsigned HEAVY_PCT = 61;
  localparam int unsigned SWAP_AT = 650;
  localparam int unsigned QUIET_AT = 1300;
  localparam int unsigned HOLD_AT = 100;
  localparam int unsigned HOLD_LEN = 300;
  localparam logic [CfgIdxW-1:0] REG_NONE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_NONE_HI = 3'd7;

  // tex_blue sits in the lowest byte of s_axis_tdata
  typedef struct packed {
    logic [ChanW-1:0] dst_red;
    logic [ChanW-1:0] dst_green;
    logic [ChanW-1:0] dst_blue;
    logic [ChanW-1:0] tex_alpha;
    logic [ChanW-1:0] tex_red;
    logic [ChanW-1:0] tex_green;
    logic [ChanW-1:0] tex_blue;
  } texel_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [IndexW-1:0] index;
  } wb_data_t;

  typedef struct {
    logic [IndexW-1:0] index;
    logic [ChanW-1:0]  blue;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  red;
    logic              outside;
    logic              last;
  } writeback_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // blitter state as predicted
  logic [DimW-1:0]   scr_w;
  logic [DimW-1:0]   tex_w;
  logic [DimW-1:0]   tex_h;
  logic [PosW-1:0]   org_x;
  logic [PosW-1:0]   org_y;
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [IndexW-1:0] row_base;

  texel_t      texel_q[$];
  writeback_t  wb_q[$];
  int unsigned sent_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          in_fire = 1'b0;

  alpha_blend_blitter_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  // floor division by 256 through an arithmetic shift of a signed product
  function automatic logic [ChanW-1:0] mix_chan(logic [ChanW-1:0] src, logic [ChanW-1:0] dst,
                                                logic [ChanW-1:0] alpha);
    int prod;
    prod = int'(alpha) * (int'(src) - int'(dst));
    return ChanW'(int'(dst) + (prod >>> ChanW));
  endfunction

  function automatic writeback_t predict_writeback(texel_t t);
    writeback_t  w;
    int unsigned tw;
    int unsigned th;
    int unsigned dcol;
    bit          row_end;
    bit          col_end;
    tw = clamp_dim(tex_w);
    th = clamp_dim(tex_h);
    dcol = org_x + col_pos;
    w.index = IndexW'(org_y * scr_w + row_base + dcol);
    w.blue = mix_chan(t.tex_blue, t.dst_blue, t.tex_alpha);
    w.green = mix_chan(t.tex_green, t.dst_green, t.tex_alpha);
    w.red = mix_chan(t.tex_red, t.dst_red, t.tex_alpha);
    w.outside = (dcol >= scr_w);
    row_end = (col_pos + 1 >= tw);
    col_end = (row_pos + 1 >= th);
    w.last = row_end && col_end;
    if (w.last) begin
      col_pos = 0;
      row_pos = 0;
      row_base = '0;
    end else if (row_end) begin
      col_pos = 0;
      row_pos = row_pos + 1;
      row_base = row_base + scr_w;
    end else begin
      col_pos = col_pos + 1;
    end
    return w;
  endfunction

  function automatic int unsigned send_idle_pct();
    if (sent_cnt < SWAP_AT) return LIGHT_PCT;
    if (sent_cnt < QUIET_AT) return HEAVY_PCT;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (sent_cnt < SWAP_AT) return HEAVY_PCT;
    if (sent_cnt < QUIET_AT) return LIGHT_PCT;
    return 0;
  endfunction

  function automatic texel_t rand_texel();
    texel_t t;
    t = InDataW'({$urandom(), $urandom()});
    case ($urandom_range(9))
      0: t.tex_alpha = '0;
      1: t.tex_alpha = '1;
      2: begin
        t.tex_alpha = '1;
        t.tex_red = '0;
        t.dst_red = '1;
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic void put_texel(logic [ChanW-1:0] a, logic [ChanW-1:0] sb,
                                    logic [ChanW-1:0] sg, logic [ChanW-1:0] sr,
                                    logic [ChanW-1:0] db, logic [ChanW-1:0] dg,
                                    logic [ChanW-1:0] dr);
    texel_t t;
    t.tex_alpha = a;
    t.tex_blue = sb;
    t.tex_green = sg;
    t.tex_red = sr;
    t.dst_blue = db;
    t.dst_green = dg;
    t.dst_red = dr;
    texel_q.push_back(t);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_dim();
    case ($urandom_range(9))
      0: return '0;
      1: return CfgDataW'($urandom_range(9, 40));
      2: return '1;
      default: return CfgDataW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_pos();
    case ($urandom_range(4))
      0: return '0;
      1: return CfgDataW'(2047);
      default: return CfgDataW'($urandom());
    endcase
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      abb_pkg::REG_SCREEN_WIDTH:   scr_w = val;
      abb_pkg::REG_TEXTURE_WIDTH:  tex_w = val;
      abb_pkg::REG_TEXTURE_HEIGHT: tex_h = val;
      abb_pkg::REG_POS_X:          org_x = val[PosW-1:0];
      abb_pkg::REG_POS_Y:          org_y = val[PosW-1:0];
      default: ;
    endcase
    // known registers restart the walk, unknown ones are dropped
    if (idx <= abb_pkg::REG_POS_Y) begin
      col_pos = 0;
      row_pos = 0;
      row_base = '0;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (texel_q.size() != 0 || s_axis_tvalid || wb_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // pixel driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (texel_q.size() != 0 &&
            (hold_left != 0 || $urandom_range(99) >= send_idle_pct())) begin
          s_axis_tdata <= texel_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // write-back receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // one long back-pressure stretch so the pipeline fills and stalls its input
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // predictor on the input side, checker on the output side
  always @(posedge clk_i) begin
    writeback_t exp_wb;
    wb_data_t   got;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      wb_q.push_back(predict_writeback(texel_t'(s_axis_tdata)));
      sent_cnt++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (wb_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected write-back transaction: index %0d", got.index);
      end else begin
        exp_wb = wb_q.pop_front();
        if (got.index !== exp_wb.index || got.blue !== exp_wb.blue ||
            got.green !== exp_wb.green || got.red !== exp_wb.red ||
            m_axis_tuser !== exp_wb.outside || m_axis_tlast !== exp_wb.last) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display({"mismatch (exp/got): index %0d/%0d bgr %0d,%0d,%0d/%0d,%0d,%0d",
                      " outside %0b/%0b last %0b/%0b"},
                     exp_wb.index, got.index, exp_wb.blue, exp_wb.green, exp_wb.red,
                     got.blue, got.green, got.red, exp_wb.outside, m_axis_tuser,
                     exp_wb.last, m_axis_tlast);
        end
      end
    end
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned rnd_sent;
    int unsigned n;
    scr_w = abb_pkg::SCREEN_WIDTH_RST;
    tex_w = abb_pkg::TEXTURE_WIDTH_RST;
    tex_h = abb_pkg::TEXTURE_HEIGHT_RST;
    org_x = abb_pkg::POS_X_RST;
    org_y = abb_pkg::POS_Y_RST;
    col_pos = 0;
    row_pos = 0;
    row_base = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // channel extremes on the reset geometry
    put_texel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    put_texel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    put_texel(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd17, 8'd200);
    put_texel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    put_texel(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    put_texel(8'd128, 8'd1, 8'd0, 8'd200, 8'd0, 8'd1, 8'd100);
    put_texel(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1);
    wait_drained();

    // zero screen width and zero texture size: every pixel is last and clipped
    write_reg(abb_pkg::REG_SCREEN_WIDTH, '0);
    write_reg(abb_pkg::REG_TEXTURE_WIDTH, '0);
    write_reg(abb_pkg::REG_TEXTURE_HEIGHT, '0);
    write_reg(abb_pkg::REG_POS_X, '1);
    write_reg(abb_pkg::REG_POS_Y, '1);
    repeat (3) texel_q.push_back(rand_texel());
    wait_drained();

    // clipping at the right edge, index wrap, write to an unknown register mid-walk
    write_reg(abb_pkg::REG_SCREEN_WIDTH, CfgDataW'(2048));
    write_reg(abb_pkg::REG_TEXTURE_WIDTH, CfgDataW'(3));
    write_reg(abb_pkg::REG_TEXTURE_HEIGHT, CfgDataW'(2));
    write_reg(abb_pkg::REG_POS_X, CfgDataW'(2046));
    repeat (2) texel_q.push_back(rand_texel());
    wait_drained();
    write_reg(REG_NONE_HI, '1);
    repeat (6) texel_q.push_back(rand_texel());
    wait_drained();

    // oversized width is clamped: a long run along one wide row
    write_reg(abb_pkg::REG_SCREEN_WIDTH, '1);
    write_reg(abb_pkg::REG_TEXTURE_WIDTH, '1);
    write_reg(abb_pkg::REG_TEXTURE_HEIGHT, CfgDataW'(1));
    write_reg(abb_pkg::REG_POS_X, '0);
    write_reg(abb_pkg::REG_POS_Y, CfgDataW'($urandom_range(2047)));
    repeat (BIG_ROW_ITEMS) texel_q.push_back(rand_texel());
    wait_drained();

    rnd_sent = 0;
    while (rnd_sent < RAND_ITEMS) begin
      if ($urandom_range(4) != 0) begin
        case ($urandom_range(5))
          0: write_reg(abb_pkg::REG_SCREEN_WIDTH, '0);
          1: write_reg(abb_pkg::REG_SCREEN_WIDTH, CfgDataW'(1));
          2: write_reg(abb_pkg::REG_SCREEN_WIDTH, CfgDataW'(2048));
          3: write_reg(abb_pkg::REG_SCREEN_WIDTH, '1);
          default: write_reg(abb_pkg::REG_SCREEN_WIDTH, CfgDataW'($urandom()));
        endcase
      end
      if ($urandom_range(4) != 0) write_reg(abb_pkg::REG_TEXTURE_WIDTH, pick_dim());
      if ($urandom_range(4) != 0) write_reg(abb_pkg::REG_TEXTURE_HEIGHT, pick_dim());
      if ($urandom_range(3) != 0) write_reg(abb_pkg::REG_POS_X, pick_pos());
      if ($urandom_range(3) != 0) write_reg(abb_pkg::REG_POS_Y, pick_pos());
      if ($urandom_range(4) == 0)
        write_reg(CfgIdxW'($urandom_range(REG_NONE_LO, REG_NONE_HI)), CfgDataW'($urandom()));
      n = $urandom_range(10, 120);
      repeat (n) texel_q.push_back(rand_texel());
      rnd_sent += n;
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
